// File: rtl/core/scpt_pkg.sv
package scpt_pkg;

  localparam int MAX_POOLS = 64;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [31:0] address;
    logic [30:0] alloc_size;
  } scpt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [0:0]  size_in_class;
    logic [31:0] rounded_size;
    logic [6:0]  pools_in_use;
    logic [36:0] bytes_reserved;
    logic [37:0] bytes_used;
  } scpt_out_t;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_CREATED  = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [0:0] OP_ALLOC = 1'b0;
  localparam logic [0:0] OP_FREE  = 1'b1;

  localparam logic [1:0] REG_GRANULARITY = 2'd0;
  localparam logic [1:0] REG_POOL_SIZE   = 2'd1;
  localparam logic [1:0] REG_MIN_BYTES   = 2'd2;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd3;

endpackage

// File: rtl/core/scpt_ram.sv
module scpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/scpt_div.sv
// Restoring divider, one quotient bit per cycle: q = num / den.
module scpt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [5:0]  cnt;
  logic        busy;
  logic [31:0] n;
  logic [17:0] rem;
  logic [17:0] trial;

  assign trial = {rem[16:0], n[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      n <= {n[30:0], 1'b0};
      if (!trial[17]) begin
        rem <= trial;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[16:0], n[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/size_class_pool_tracker_unit.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_stall   | scpt_in_t
// out     | out | out_valid/out_stall | scpt_out_t
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// From acceptance to out_valid an item passes a divide for rounding, a search
// of the live pools newest first (one RAM read per pool searched), then update
// and multiply. A release also shifts every newer pool down by one entry before
// the final update.
// Reset is synchronous; RAMs are not cleared, only pool_count governs reads.
// in_stall stays high from acceptance until the result is taken.
module size_class_pool_tracker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  scpt_pkg::scpt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scpt_pkg::scpt_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import scpt_pkg::*;

  localparam int AW = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int CW = $clog2(MAX_POOLS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_SREQ  = 4'd2;
  localparam logic [3:0] S_SCHK  = 4'd3;
  localparam logic [3:0] S_UREQ  = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_MREQ  = 4'd6;
  localparam logic [3:0] S_MWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state;
  logic [16:0] granularity;
  logic [30:0] pool_size;
  logic [30:0] min_bytes;
  logic [30:0] max_bytes;
  logic [CW-1:0] pool_count;
  logic [37:0] total_used;
  scpt_in_t    item;
  logic [31:0] rounded;
  logic [CW-1:0] idx;
  logic [AW-1:0] hit;
  logic        found;
  logic [31:0] old_used;
  logic [31:0] new_used;
  logic [2:0]  status;
  logic [36:0] reserved;
  scpt_out_t   result;

  logic [16:0] g_eff;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] num;

  logic          b_we, u_we;
  logic [AW-1:0] b_waddr, u_waddr, raddr;
  logic [31:0]   b_wdata, u_wdata, b_rdata, u_rdata;
  logic [32:0]   offs;
  logic [32:0]   sum_sat;

  assign g_eff = (granularity == '0) ? 17'd1 : granularity;
  // divider loads at acceptance, so take the size straight from the port
  assign num   = {1'b0, in_data.alloc_size} + {15'd0, g_eff} - 32'd1;

  scpt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (g_eff),
    .done (div_done),
    .quo  (div_q)
  );

  scpt_ram #(.WIDTH(32), .DEPTH(MAX_POOLS)) u_base (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(raddr), .rdata(b_rdata)
  );

  scpt_ram #(.WIDTH(32), .DEPTH(MAX_POOLS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(raddr), .rdata(u_rdata)
  );

  assign offs    = {1'b0, item.address} - {1'b0, b_rdata};
  assign sum_sat = {1'b0, u_rdata} + {1'b0, rounded};

  always_comb begin
    raddr   = idx[AW-1:0];
    b_we    = 1'b0;
    u_we    = 1'b0;
    b_waddr = hit;
    u_waddr = hit;
    b_wdata = item.address;
    u_wdata = new_used;
    div_start = (state == S_IDLE) && in_valid;
    case (state)
      // fetch the entry that S_SCHK will compare
      S_SREQ: raddr = AW'(idx - CW'(1));
      S_UREQ: raddr = hit;
      S_MREQ: raddr = idx[AW-1:0];
      S_UPD: begin
        if (!found) begin
          if (item.opcode == OP_ALLOC && pool_count < CW'(MAX_POOLS)) begin
            b_we    = 1'b1;
            u_we    = 1'b1;
            b_waddr = pool_count[AW-1:0];
            u_waddr = pool_count[AW-1:0];
            u_wdata = rounded;
          end
        end
      end
      S_MWR: begin
        b_we    = 1'b1;
        u_we    = 1'b1;
        b_waddr = AW'(idx - CW'(1));
        u_waddr = AW'(idx - CW'(1));
        b_wdata = b_rdata;
        u_wdata = u_rdata;
      end
      S_FIN: begin
        u_we = found && (status == ST_UPDATED);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      granularity <= 17'd16;
      pool_size   <= 31'd65536;
      min_bytes   <= '0;
      max_bytes   <= 31'h7FFF_FFFF;
      pool_count  <= '0;
      total_used  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRANULARITY: granularity <= cfg_data[16:0];
          REG_POOL_SIZE:   pool_size   <= cfg_data;
          REG_MIN_BYTES:   min_bytes   <= cfg_data;
          REG_MAX_BYTES:   max_bytes   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rounded <= 32'(div_q * {15'd0, g_eff});
            idx     <= pool_count;
            found   <= 1'b0;
            state   <= S_SREQ;
          end
        end
        S_SREQ: begin
          // scan newest to oldest
          if (idx == '0) begin
            state <= S_UREQ;
          end else begin
            idx   <= idx - CW'(1);
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (!offs[32] && offs < {2'd0, pool_size}) begin
            found <= 1'b1;
            hit   <= idx[AW-1:0];
            state <= S_UREQ;
          end else begin
            state <= S_SREQ;
          end
        end
        S_UREQ: state <= S_UPD;
        S_UPD: begin
          old_used <= u_rdata;
          if (!found) begin
            if (item.opcode == OP_FREE) begin
              status <= ST_NO_MATCH;
            end else if (pool_count >= CW'(MAX_POOLS)) begin
              status <= ST_FULL;
            end else begin
              status     <= ST_CREATED;
              pool_count <= pool_count + CW'(1);
              total_used <= total_used + {6'd0, rounded};
            end
            state <= S_MUL;
          end else if (item.opcode == OP_ALLOC) begin
            new_used <= sum_sat[32] ? 32'hFFFF_FFFF : sum_sat[31:0];
            status   <= ST_UPDATED;
            state    <= S_FIN;
          end else if (u_rdata > rounded) begin
            new_used <= u_rdata - rounded;
            status   <= ST_UPDATED;
            state    <= S_FIN;
          end else begin
            new_used <= '0;
            status   <= ST_RELEASED;
            idx      <= {1'b0, hit} + CW'(1);
            state    <= S_MREQ;
          end
        end
        S_MREQ: begin
          if (idx >= pool_count) begin
            state <= S_FIN;
          end else begin
            state <= S_MWR;
          end
        end
        S_MWR: begin
          idx   <= idx + CW'(1);
          state <= S_MREQ;
        end
        S_FIN: begin
          total_used <= total_used - {6'd0, old_used} + {6'd0, new_used};
          if (status == ST_RELEASED) begin
            pool_count <= pool_count - CW'(1);
          end
          state <= S_MUL;
        end
        S_MUL: begin
          reserved <= 37'({30'd0, pool_count} * {6'd0, pool_size});
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    result.status         = status;
    result.size_in_class  = (item.alloc_size >= min_bytes) && (item.alloc_size <= max_bytes);
    result.rounded_size   = rounded;
    result.pools_in_use   = 7'(pool_count);
    result.bytes_reserved = reserved;
    result.bytes_used     = total_used;
  end

  assign out_data = result;
  assign in_stall = (state != S_IDLE);

endmodule

// File: rtl/core/scpt_checker.sv
module scpt_assertions (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input scpt_pkg::scpt_out_t out_data
);
  import scpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transaction");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_FULL)
    else $error("bad status");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> out_data.pools_in_use != 7'd0)
    else $error("full with no pools");

endmodule

bind size_class_pool_tracker_unit scpt_assertions u_scpt_assertions (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: dv/scpt_checker.sv
module scpt_checker #(
  parameter int MAX_POOLS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  scpt_pkg::scpt_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  scpt_pkg::scpt_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import scpt_pkg::*;

  logic [16:0] granularity;
  logic [30:0] pool_span;
  logic [30:0] min_bytes;
  logic [30:0] max_bytes;

  logic [31:0] base_tbl [MAX_POOLS];
  logic [31:0] used_tbl [MAX_POOLS];
  int          live_pools;

  scpt_out_t   expected_q[$];
  int          mismatches;

  assign pending = expected_q.size();
  assign fail_count = mismatches;

  function automatic int newest_pool(logic [31:0] addr);
    for (int i = live_pools - 1; i >= 0; i--) begin
      if (addr >= base_tbl[i] && longint'(addr - base_tbl[i]) < longint'(pool_span))
        return i;
    end
    return -1;
  endfunction

  // Apply one transaction to the pool table and return its result.
  function automatic scpt_out_t account_item(scpt_in_t item);
    scpt_out_t       res;
    longint unsigned g;
    longint unsigned rounded;
    longint unsigned acc;
    logic [31:0]     r32;
    int              k;
    g = (granularity == 0) ? 1 : granularity;
    rounded = ((longint'(item.alloc_size) + g - 1) / g) * g;
    r32 = rounded[31:0];
    k = newest_pool(item.address);
    if (item.opcode == OP_ALLOC) begin
      if (k >= 0) begin
        acc = longint'(used_tbl[k]) + longint'(r32);
        used_tbl[k] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        res.status = ST_UPDATED;
      end else if (live_pools >= MAX_POOLS) begin
        res.status = ST_FULL;
      end else begin
        base_tbl[live_pools] = item.address;
        used_tbl[live_pools] = r32;
        live_pools++;
        res.status = ST_CREATED;
      end
    end else if (k < 0) begin
      res.status = ST_NO_MATCH;
    end else begin
      used_tbl[k] = (used_tbl[k] > r32) ? used_tbl[k] - r32 : 32'd0;
      if (used_tbl[k] == 0) begin
        // drop the pool, keep the rest in age order
        for (int j = k; j + 1 < live_pools; j++) begin
          base_tbl[j] = base_tbl[j + 1];
          used_tbl[j] = used_tbl[j + 1];
        end
        live_pools--;
        res.status = ST_RELEASED;
      end else begin
        res.status = ST_UPDATED;
      end
    end
    acc = 0;
    for (int j = 0; j < live_pools; j++) acc += used_tbl[j];
    res.size_in_class = (item.alloc_size >= min_bytes && item.alloc_size <= max_bytes);
    res.rounded_size = r32;
    res.pools_in_use = live_pools[6:0];
    res.bytes_reserved = 37'(longint'(live_pools) * longint'(pool_span));
    res.bytes_used = acc[37:0];
    return res;
  endfunction

  task automatic report(string what, longint unsigned exp_v, longint unsigned act_v);
    if (mismatches < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    scpt_out_t exp_r;
    if (rst) begin
      granularity <= 17'd16;
      pool_span   <= 31'd65536;
      min_bytes   <= 31'd0;
      max_bytes   <= 31'h7FFF_FFFF;
      live_pools  = 0;
      expected_q.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRANULARITY: granularity <= cfg_data[16:0];
          REG_POOL_SIZE:   pool_span   <= cfg_data;
          REG_MIN_BYTES:   min_bytes   <= cfg_data;
          REG_MAX_BYTES:   max_bytes   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(account_item(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", 0, 1);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.status != exp_r.status)
            report("status", exp_r.status, out_data.status);
          if (out_data.size_in_class != exp_r.size_in_class)
            report("size_in_class", exp_r.size_in_class, out_data.size_in_class);
          if (out_data.rounded_size != exp_r.rounded_size)
            report("rounded_size", exp_r.rounded_size, out_data.rounded_size);
          if (out_data.pools_in_use != exp_r.pools_in_use)
            report("pools_in_use", exp_r.pools_in_use, out_data.pools_in_use);
          if (out_data.bytes_reserved != exp_r.bytes_reserved)
            report("bytes_reserved", exp_r.bytes_reserved, out_data.bytes_reserved);
          if (out_data.bytes_used != exp_r.bytes_used)
            report("bytes_used", exp_r.bytes_used, out_data.bytes_used);
        end
      end
    end
  end

endmodule

// File: dv/tb_size_class_pool_tracker_unit.sv
module tb_size_class_pool_tracker_unit;
  import scpt_pkg::*;

  localparam int  RAND_ITEMS  = 280;
  localparam int  CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  scpt_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  scpt_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GRANULARITY;
  logic [30:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          hold_left = 0;
  int          stall_on = 0;
  int          send_gap_on = 1;
  int unsigned cur_span = 65536;
  logic [31:0] addr_pool[$];

  size_class_pool_tracker_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scpt_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: after each taken transaction, stall for a random count while stall_on is set.
  always @(posedge clk) begin
    int d;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      d = stall_on ? $urandom_range(0, 16) : 0;
      out_stall <= (d != 0);
      hold_left <= d;
    end else if (hold_left > 0) begin
      out_stall <= (hold_left > 1);
      hold_left <= hold_left - 1;
    end
  end

  task automatic send_item(logic [0:0] op, logic [31:0] addr, logic [30:0] size);
    int gap;
    gap = send_gap_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, address: addr, alloc_size: size};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [30:0] g, logic [30:0] span, logic [30:0] lo,
                              logic [30:0] hi);
    logic [30:0] vals[4];
    vals = '{g, span, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_span = 32'(span);
  endtask

  function automatic logic [30:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1:    return 31'($urandom_range(0, 32'h7FFF_FFFF));
      2:       return 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
      default: return 31'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [31:0] near_pool();
    logic [31:0] b;
    b = addr_pool.size() ? addr_pool[$urandom_range(0, addr_pool.size() - 1)] : $urandom;
    if (cur_span > 1 && $urandom_range(0, 3) != 0)
      return b + $urandom_range(0, cur_span - 1);
    return b;
  endfunction

  task automatic random_phase(int n);
    logic [31:0] a;
    int          r;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        send_gap_on = $urandom_range(0, 2) != 0;
        stall_on    = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_item(OP_ALLOC, near_pool(), pick_size());
      end else if (r < 55) begin
        a = $urandom;
        if (addr_pool.size() >= 80) void'(addr_pool.pop_front());
        addr_pool.push_back(a);
        send_item(OP_ALLOC, a, pick_size());
      end else if (r < 92) begin
        // frees with a large size tend to release the pool
        send_item(OP_FREE, near_pool(),
                  $urandom_range(0, 1) ? 31'h7FFF_FFFF : pick_size());
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom,
                  31'($urandom_range(0, 32'h7FFF_FFFF)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed checks at the reset settings
    send_item(OP_ALLOC, 32'h0, 31'd0);
    send_item(OP_FREE,  32'h0, 31'd0);
    send_item(OP_FREE,  32'h1234, 31'd5);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_FREE,  32'hFFFF_FFFF, 31'd1);
    send_item(OP_ALLOC, 32'd1000, 31'd1);
    send_item(OP_ALLOC, 32'd1000 + 32'd65535, 31'd17);
    send_item(OP_ALLOC, 32'd1000 + 32'd65536, 31'd32);
    send_item(OP_ALLOC, 32'd999, 31'd15);
    send_item(OP_FREE,  32'd1100, 31'd16);
    send_item(OP_FREE,  32'd1100, 31'd100);
    send_item(OP_FREE,  32'd66536, 31'd40);
    send_item(OP_FREE,  32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_FREE,  32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_FREE,  32'd999, 31'h7FFF_FFFF);
    drain();

    // zero pool size and zero granularity: every allocate creates a pool until the table fills
    program_regs(31'd0, 31'd0, 31'd0, 31'd0);
    for (int i = 0; i < 70; i++) send_item(OP_ALLOC, $urandom, 31'($urandom_range(0, 3)));
    send_item(OP_FREE, 32'h0, 31'd0);
    drain();

    program_regs(31'd1, 31'd4096, 31'd100, 31'd2000);
    random_phase(RAND_ITEMS);
    drain();

    program_regs(31'h1FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_phase(RAND_ITEMS);
    drain();

    program_regs(31'd65536, 31'd1, 31'd0, 31'h7FFF_FFFF);
    random_phase(RAND_ITEMS);
    drain();

    for (int p = 0; p < 3; p++) begin
      program_regs(31'($urandom_range(0, 32'h1FFFF)), 31'($urandom_range(1, 1 << 20)),
                   31'($urandom_range(0, 2048)),
                   31'($urandom_range(1024, 32'h7FFF_FFFF)));
      random_phase(RAND_ITEMS);
      drain();
    end

    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/scpt_pkg.sv
rtl/core/scpt_ram.sv
rtl/core/scpt_div.sv
rtl/core/size_class_pool_tracker_unit.sv
rtl/core/scpt_checker.sv
dv/scpt_checker.sv
dv/tb_size_class_pool_tracker_unit.sv
